// ===== sv/epoch_seconds_to_calendar_core_assert.svh =====
// Assertion macros shared by the calendar conversion RTL.
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define ESC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define ESC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/esc_pkg.sv =====
// Types, constants and calendar helpers for the epoch-to-calendar converter.
package esc_pkg;

  // Divider datapath widths.
  localparam int DIV_W  = 33;
  localparam int DEN_W  = 17;
  localparam int QUO_W  = 16;
  localparam int MUL_W  = 27;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SH_W   = 6;

  // Constant divisors.
  localparam logic [DEN_W-1:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [DEN_W-1:0] SEC_PER_HOUR  = 17'd3600;
  localparam logic [DEN_W-1:0] SEC_PER_MIN   = 17'd60;
  localparam logic [DEN_W-1:0] DAYS_PER_WEEK = 17'd7;

  // Reciprocals for the constant divisions. The dividend, shifted right past
  // the power-of-two factor of the divisor, is multiplied by ceil(2^s / d) for
  // the odd part d and shifted right by s. For each pass the rounding error
  // times the largest shifted dividend stays below 2^s, so the quotient is exact.
  localparam logic [MUL_W-1:0] MAGIC_DAY  = 27'd101806633; // 86400 = 128 * 675
  localparam logic [SH_W-1:0]  SH_DAY     = 6'd36;
  localparam logic [MUL_W-1:0] MAGIC_HOUR = 27'd9321;      // 3600 = 16 * 225
  localparam logic [SH_W-1:0]  SH_HOUR    = 6'd21;
  localparam logic [MUL_W-1:0] MAGIC_MIN  = 27'd1093;      // 60 = 4 * 15
  localparam logic [SH_W-1:0]  SH_MIN     = 6'd14;
  localparam logic [MUL_W-1:0] MAGIC_WEEK = 27'd74899;
  localparam logic [SH_W-1:0]  SH_WEEK    = 6'd19;

  localparam logic [11:0]       BASE_YEAR   = 12'd1970;
  localparam logic [11:0]       SKIP_LEAP   = 12'd2100;
  localparam logic signed [4:0] OFFSET_RST  = 5'sd8;
  localparam logic [3:0]        MONTH_JAN   = 4'd1;
  localparam logic [3:0]        MONTH_FEB   = 4'd2;
  localparam logic [3:0]        MONTH_DEC   = 4'd12;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] recip_in;
    logic [MUL_W-1:0] magic;
    logic [SH_W-1:0]  shift;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quot;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

  // Divider steps.
  typedef enum logic [2:0] {
    DV_IDLE,
    DV_QUO,
    DV_SHIFT,
    DV_BACK,
    DV_REM
  } dv_phase_t;

  // Conversion sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_WEEK,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } esc_state_t;

  // Gregorian leap rule for the reachable years 1970..2106, where 2000 is
  // the only century year divisible by 400 and 2100 the only one that is not.
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != SKIP_LEAP);
  endfunction

  // Length of a month in days.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/esc_div.sv =====
// Shared constant divider: reciprocal multiply, shift, then multiply back for the remainder.
`include "epoch_seconds_to_calendar_core_assert.svh"

module esc_div
  import esc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  dv_phase_t         phase_r, phase_nxt;
  logic              done_r, done_nxt;
  logic [MUL_W-1:0]  x_r;
  logic [MUL_W-1:0]  magic_r;
  logic [SH_W-1:0]   shift_r;
  logic [DIV_W-1:0]  dvd_r;
  logic [DEN_W-1:0]  den_r;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;

  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0] prod_sh;
  logic [DIV_W-1:0]  back_diff;

  // The one multiplier, shared by the reciprocal and the multiply-back steps.
  assign mul_p     = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
  assign prod_sh   = prod_r >> shift_r;
  assign back_diff = dvd_r - prod_r[DIV_W-1:0];

  // Step sequence: each pass runs through DV_QUO, DV_SHIFT, DV_BACK and DV_REM, then done pulses once.
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      DV_IDLE:  if (req.start) phase_nxt = DV_QUO;
      DV_QUO:   phase_nxt = DV_SHIFT;
      DV_SHIFT: phase_nxt = DV_BACK;
      DV_BACK:  phase_nxt = DV_REM;
      DV_REM:   phase_nxt = DV_IDLE;
      default:  phase_nxt = DV_IDLE;
    endcase
  end

  // Step outputs: multiplier operands and the next datapath values.
  always_comb begin
    mul_a    = x_r;
    mul_b    = magic_r;
    prod_nxt = prod_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    unique case (phase_r)
      DV_IDLE:  ;
      DV_QUO:   prod_nxt = mul_p;
      DV_SHIFT: quo_nxt  = prod_sh[QUO_W-1:0];
      DV_BACK: begin
        mul_a    = {{(MUL_W-QUO_W){1'b0}}, quo_r};
        mul_b    = {{(MUL_W-DEN_W){1'b0}}, den_r};
        prod_nxt = mul_p;
      end
      DV_REM: begin
        rem_nxt  = back_diff[DEN_W-1:0];
        done_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  // Operand and datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r     <= req.recip_in;
      magic_r <= req.magic;
      shift_r <= req.shift;
      dvd_r   <= req.dividend;
      den_r   <= req.divisor;
    end
    prod_r <= prod_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp.busy = (phase_r != DV_IDLE);
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

  // A new division never starts while one is running.
  `ESC_ASSERT_IMP(a_no_start_busy, req.start, phase_r == DV_IDLE, "divider started while busy")
  // Done lasts one cycle only.
  `ESC_ASSERT_NXT(a_done_pulse, done_r, !done_r, "divider done held")
  // The end of a run always reports done.
  `ESC_ASSERT_IMP(a_fall_done, $fell(rsp.busy), done_r, "divider stopped without done")
  // The finished remainder lies below the divisor.
  `ESC_ASSERT_IMP(a_rem_bound, done_r, rem_r < den_r, "divider remainder out of range")

endmodule

// ===== sv/epoch_seconds_to_calendar_core.sv =====
// Top level: converts Unix seconds to local calendar date and time.
//
// Input channel in_*: one request per item, in_tdata is the 32-bit count of
// seconds since 1970-01-01 00:00:00 UTC. Result channel out_*: one result per
// request. The configured offset in whole hours (cfg_wdata, signed) is added
// to the time before it is split; a local time before the epoch gives the
// epoch itself with out_tuser set.
// Steps: the four constant divisions (day, hour, minute, weekday) run in turn
// in the shared reciprocal divider; the year loop then removes one whole year
// per cycle (up to 136), the month walk one whole month per cycle (up to 11),
// and the output register is loaded last. One request is converted at a time
// and in_tready is high only while the sequencer idles, so a new request is
// taken only after the last result has been loaded into the output register.
// The result sits in an output register, so the next request is taken while
// a result still waits on out_tready; a stalled receiver only holds the
// sequencer once a second result is ready.
// Reset (rst_n low, synchronous) empties the block and sets the offset to +8.
`include "epoch_seconds_to_calendar_core_assert.svh"

module epoch_seconds_to_calendar_core
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: utc_offset_hours, signed.
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  // Input: [31:0] epoch_seconds.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // Result.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
  // [31:26] minute, [37:32] second, [40:38] weekday, [47:41] zero.
  output logic [47:0] out_tdata,
  // [0] clamped.
  output logic        out_tuser
);

  esc_state_t        state_r, state_nxt;
  logic signed [4:0] off_r;
  logic              clamped_r, clamped_nxt;
  logic [15:0]       days_r, days_nxt;
  logic [15:0]       doy_r, doy_nxt;
  logic [11:0]       year_r, year_nxt;
  logic [3:0]        month_r, month_nxt;
  logic [4:0]        hour_r, hour_nxt;
  logic [5:0]        min_r, min_nxt;
  logic [5:0]        sec_r, sec_nxt;
  logic [2:0]        wday_r, wday_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [47:0]       out_data_r, out_data_nxt;
  logic              out_user_r, out_user_nxt;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              in_fire;
  logic              out_load;
  logic signed [17:0] ofs_sec;
  logic signed [33:0] local_s;
  logic              before_epoch;
  logic [DIV_W-1:0]  t_loc;
  logic              leap;
  logic [8:0]        ylen;
  logic [4:0]        mlen;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Local time: the offset in seconds added to the unsigned count, clamped at zero.
  assign ofs_sec      = $signed({{13{off_r[4]}}, off_r}) * $signed(18'sd3600);
  assign local_s      = $signed({2'b00, in_tdata}) + $signed({{16{ofs_sec[17]}}, ofs_sec});
  assign before_epoch = local_s[33];
  assign t_loc        = before_epoch ? '0 : local_s[DIV_W-1:0];

  // Year and month lengths for the current walk position.
  assign leap = is_leap(year_r);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(month_r, leap);

  esc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire)      state_nxt = ST_DAY;
      ST_DAY:   if (div_rsp.done) state_nxt = ST_HOUR;
      ST_HOUR:  if (div_rsp.done) state_nxt = ST_MIN;
      ST_MIN:   if (div_rsp.done) state_nxt = ST_WEEK;
      ST_WEEK:  if (div_rsp.done) state_nxt = ST_YEAR;
      ST_YEAR:  if (doy_r < {7'd0, ylen}) state_nxt = ST_MONTH;
      ST_MONTH: begin
        if (month_r == MONTH_DEC || doy_r < {11'd0, mlen}) state_nxt = ST_DONE;
      end
      ST_DONE:  if (out_load)     state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: divider requests and the captured fields.
  always_comb begin
    div_req       = '0;
    clamped_nxt   = clamped_r;
    days_nxt      = days_r;
    doy_nxt       = doy_r;
    year_nxt      = year_r;
    month_nxt     = month_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    sec_nxt       = sec_r;
    wday_nxt      = wday_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    unique case (state_r)
      ST_IDLE: begin
        // Day count: the low seven bits drop out of the 128 in 86400.
        if (in_fire) begin
          clamped_nxt      = before_epoch;
          div_req.start    = 1'b1;
          div_req.recip_in = {1'b0, t_loc[DIV_W-1:7]};
          div_req.magic    = MAGIC_DAY;
          div_req.shift    = SH_DAY;
          div_req.dividend = t_loc;
          div_req.divisor  = SEC_PER_DAY;
        end
      end
      ST_DAY: begin
        // Hour: the low four bits drop out of the 16 in 3600.
        if (div_rsp.done) begin
          days_nxt         = div_rsp.quot;
          div_req.start    = 1'b1;
          div_req.recip_in = {14'd0, div_rsp.rem[16:4]};
          div_req.magic    = MAGIC_HOUR;
          div_req.shift    = SH_HOUR;
          div_req.dividend = {{(DIV_W-DEN_W){1'b0}}, div_rsp.rem};
          div_req.divisor  = SEC_PER_HOUR;
        end
      end
      ST_HOUR: begin
        // Minute: the low two bits drop out of the 4 in 60.
        if (div_rsp.done) begin
          hour_nxt         = div_rsp.quot[4:0];
          div_req.start    = 1'b1;
          div_req.recip_in = {17'd0, div_rsp.rem[11:2]};
          div_req.magic    = MAGIC_MIN;
          div_req.shift    = SH_MIN;
          div_req.dividend = {21'd0, div_rsp.rem[11:0]};
          div_req.divisor  = SEC_PER_MIN;
        end
      end
      ST_MIN: begin
        if (div_rsp.done) begin
          min_nxt          = div_rsp.quot[5:0];
          sec_nxt          = div_rsp.rem[5:0];
          div_req.start    = 1'b1;
          div_req.recip_in = {11'd0, days_r};
          div_req.magic    = MAGIC_WEEK;
          div_req.shift    = SH_WEEK;
          div_req.dividend = {17'd0, days_r};
          div_req.divisor  = DAYS_PER_WEEK;
        end
      end
      ST_WEEK: begin
        if (div_rsp.done) begin
          wday_nxt = div_rsp.rem[2:0];
          doy_nxt  = days_r;
          year_nxt = BASE_YEAR;
        end
      end
      ST_YEAR: begin
        // Remove one whole year per cycle.
        if (doy_r < {7'd0, ylen}) begin
          month_nxt = MONTH_JAN;
        end else begin
          doy_nxt  = doy_r - {7'd0, ylen};
          year_nxt = year_r + 12'd1;
        end
      end
      ST_MONTH: begin
        // Remove one whole month per cycle; December takes the rest.
        if (!(month_r == MONTH_DEC || doy_r < {11'd0, mlen})) begin
          doy_nxt   = doy_r - {11'd0, mlen};
          month_nxt = month_r + 4'd1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, wday_r, sec_r, min_r, hour_r,
                           doy_r[4:0] + 5'd1, month_r, year_r};
          out_user_nxt  = clamped_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      off_r       <= OFFSET_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        off_r <= $signed(cfg_wdata);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    clamped_r  <= clamped_nxt;
    days_r     <= days_nxt;
    doy_r      <= doy_nxt;
    year_r     <= year_nxt;
    month_r    <= month_nxt;
    hour_r     <= hour_nxt;
    min_r      <= min_nxt;
    sec_r      <= sec_nxt;
    wday_r     <= wday_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // The divider is idle whenever a new request can be taken.
  `ESC_ASSERT_IMP(a_idle_div, in_tready, !div_rsp.busy, "divider busy while idle")
  // Divider results only arrive during the division passes.
  `ESC_ASSERT_IMP(a_done_state, div_rsp.done,
                  state_r == ST_DAY || state_r == ST_HOUR || state_r == ST_MIN ||
                  state_r == ST_WEEK, "divider done outside a division pass")
  // The month walk stays within the year.
  `ESC_ASSERT_IMP(a_month_range, state_r == ST_MONTH || state_r == ST_DONE,
                  month_r >= MONTH_JAN && month_r <= MONTH_DEC, "month out of range")
  // A shown result holds a real calendar position.
  `ESC_ASSERT_IMP(a_out_range, out_valid_r,
                  out_data_r[11:0] <= 12'd2106 && out_data_r[25:21] <= 5'd23 &&
                  out_data_r[40:38] <= 3'd6, "result out of range")

endmodule
